// File: rtl/rvm_pkg.sv
// Shared constants, types and codes for the vector running median block.
// Used by rvm_cell, rvm_or_tree and vector_running_median; depends on nothing.
package rvm_pkg;

  localparam int unsigned VARS       = 4;
  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MED_W      = SAMPLE_W + 1;
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned VIDX_W     = (VARS > 1) ? $clog2(VARS) : 1;
  localparam int unsigned COMP_W     = 2;
  localparam int unsigned OUT_CNT_W  = 9;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned NUM_VALUES = 4;

  // Select tree: groups of cells are reduced first, then the group results.
  localparam int unsigned GROUP   = 16;
  localparam int unsigned NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic [VARS-1:0][SAMPLE_W-1:0] vec_t;

  typedef struct packed {
    vec_t lo;
    vec_t hi;
  } pick_t;

  typedef struct packed {
    logic             ins;
    vec_t             x;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] idx_lo;
    logic [IDX_W-1:0] idx_hi;
  } cell_ctl_t;

endpackage

// File: rtl/vector_running_median.sv
// Vector running median: a chain of sorting cells with a registered select tree.
// Depends on rvm_pkg, rvm_cell and rvm_or_tree.
//
// Usage: the input channel carries an operation and one sample per component.
// An add transaction inserts the samples into each component's sorted chain in
// the cycle it is accepted and gives no result, unless the store already holds
// its capacity, in which case one result with status full is given. A query
// gives one result per component with twice the median, or a single result
// with status empty when nothing is stored; last marks the final result.
// Adds can follow each other in every cycle while the output register is
// free. A full or empty result is loaded into the output register when its
// transaction is accepted. A query gives its first result after the two-stage
// select tree settles, then one result per cycle while the receiver keeps up,
// and it holds off the input until its last result is loaded. Input ready is
// high only while the sequencer is idle and the output register is free or
// being emptied in the same cycle.
// Reset clears the sample count and the sequencer; the chain contents are
// never read before being written. When the receiver stalls, the output
// register holds its result and the sequencer and input channel wait.
module vector_running_median (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic signed [rvm_pkg::SAMPLE_W-1:0] value_0_i,
  input  logic signed [rvm_pkg::SAMPLE_W-1:0] value_1_i,
  input  logic signed [rvm_pkg::SAMPLE_W-1:0] value_2_i,
  input  logic signed [rvm_pkg::SAMPLE_W-1:0] value_3_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rvm_pkg::COMP_W-1:0]        component_o,
  output logic signed [rvm_pkg::MED_W-1:0]  median_doubled_o,
  output logic [rvm_pkg::OUT_CNT_W-1:0]     sample_count_o,
  output logic [rvm_pkg::STATUS_W-1:0]      status_o,
  output logic                              last_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SETTLE = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       settle_q, settle_d;
  logic [rvm_pkg::VIDX_W-1:0] comp_q, comp_d;
  logic [rvm_pkg::CNT_W-1:0]  count_q, count_d;
  logic       out_valid_q, out_valid_d;

  logic [rvm_pkg::COMP_W-1:0]    res_comp_q, res_comp_d;
  logic signed [rvm_pkg::MED_W-1:0] res_med_q, res_med_d;
  logic [rvm_pkg::OUT_CNT_W-1:0] res_cnt_q, res_cnt_d;
  logic [rvm_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic                          res_last_q, res_last_d;
  logic                          load;

  logic accept;
  logic is_add;
  logic full;
  logic out_free;
  logic [rvm_pkg::CNT_W-2:0] half;
  logic [rvm_pkg::NUM_VALUES-1:0][rvm_pkg::SAMPLE_W-1:0] in_vals;

  rvm_pkg::cell_ctl_t ctl;
  rvm_pkg::vec_t  [rvm_pkg::CAPACITY-1:0] cell_val;
  rvm_pkg::pick_t [rvm_pkg::CAPACITY-1:0] cell_pick;
  rvm_pkg::pick_t root;
  logic [rvm_pkg::SAMPLE_W-1:0] mid_lo, mid_hi;

  assign in_vals  = {value_3_i, value_2_i, value_1_i, value_0_i};
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept   = in_valid_i && in_ready_o;
  assign is_add   = (operation_i == rvm_pkg::OP_ADD);
  assign full     = (count_q == rvm_pkg::CNT_W'(rvm_pkg::CAPACITY));
  assign half     = count_q[rvm_pkg::CNT_W-1:1];

  always_comb begin
    ctl.ins    = accept && is_add && !full;
    ctl.count  = count_q;
    ctl.idx_hi = rvm_pkg::IDX_W'(half);
    ctl.idx_lo = count_q[0] ? rvm_pkg::IDX_W'(half)
                            : rvm_pkg::IDX_W'(half) - rvm_pkg::IDX_W'(1);
    ctl.x      = '0;
    for (int v = 0; v < rvm_pkg::VARS; v++) begin
      ctl.x[v] = in_vals[v];
    end
  end

  for (genvar i = 0; i < rvm_pkg::CAPACITY; i++) begin : g_chain
    if (i == 0) begin : g_head
      rvm_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (ctl),
        .idx_i  (rvm_pkg::IDX_W'(i)),
        .prev_i ('0),
        .val_o  (cell_val[i]),
        .pick_o (cell_pick[i])
      );
    end else begin : g_body
      rvm_cell u_cell (
        .clk_i  (clk_i),
        .ctl_i  (ctl),
        .idx_i  (rvm_pkg::IDX_W'(i)),
        .prev_i (cell_val[i-1]),
        .val_o  (cell_val[i]),
        .pick_o (cell_pick[i])
      );
    end
  end

  rvm_or_tree u_tree (
    .clk_i  (clk_i),
    .leaf_i (cell_pick),
    .root_o (root)
  );

  assign mid_lo = root.lo[comp_q];
  assign mid_hi = root.hi[comp_q];

  always_comb begin
    state_d      = state_q;
    settle_d     = settle_q;
    comp_d       = comp_q;
    count_d      = count_q;
    load         = 1'b0;
    res_comp_d   = '0;
    res_med_d    = '0;
    res_cnt_d    = rvm_pkg::OUT_CNT_W'(count_q);
    res_status_d = rvm_pkg::STATUS_OK;
    res_last_d   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_add) begin
            if (full) begin
              load         = 1'b1;
              res_status_d = rvm_pkg::STATUS_FULL;
            end else begin
              count_d = count_q + rvm_pkg::CNT_W'(1);
            end
          end else if (count_q == '0) begin
            load         = 1'b1;
            res_status_d = rvm_pkg::STATUS_EMPTY;
          end else begin
            state_d  = S_SETTLE;
            settle_d = 1'b1;
            comp_d   = '0;
          end
        end
      end
      S_SETTLE: begin
        if (!settle_q) begin
          state_d = S_EMIT;
        end else begin
          settle_d = 1'b0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load         = 1'b1;
          res_comp_d   = rvm_pkg::COMP_W'(comp_q);
          res_med_d    = $signed({mid_lo[rvm_pkg::SAMPLE_W-1], mid_lo})
                       + $signed({mid_hi[rvm_pkg::SAMPLE_W-1], mid_hi});
          res_last_d   = (comp_q == rvm_pkg::VIDX_W'(rvm_pkg::VARS - 1));
          if (res_last_d) begin
            state_d = S_IDLE;
          end else begin
            comp_d = comp_q + rvm_pkg::VIDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      settle_q    <= 1'b0;
      comp_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      settle_q    <= settle_d;
      comp_q      <= comp_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_comp_q   <= res_comp_d;
      res_med_q    <= res_med_d;
      res_cnt_q    <= res_cnt_d;
      res_status_q <= res_status_d;
      res_last_q   <= res_last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign component_o      = res_comp_q;
  assign median_doubled_o = res_med_q;
  assign sample_count_o   = res_cnt_q;
  assign status_o         = res_status_q;
  assign last_o           = res_last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rvm_pkg::CNT_W'(rvm_pkg::CAPACITY))
    else $error("sample count exceeds capacity");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_status_q == rvm_pkg::STATUS_FULL)
      |-> count_q == rvm_pkg::CNT_W'(rvm_pkg::CAPACITY))
    else $error("full status given while the store is not full");

  a_no_insert_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && $past(state_q == S_EMIT)) |-> $stable(count_q))
    else $error("store changed while query results were being given");

  a_ok_last_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_status_q == rvm_pkg::STATUS_OK && res_last_q)
      |-> res_comp_q == rvm_pkg::COMP_W'(rvm_pkg::VARS - 1))
    else $error("last flag set on a result before the final component");
`endif

endmodule

// File: rtl/rvm_cell.sv
// One position of the sorted chain: holds one sample per component.
// Depends on rvm_pkg.
module rvm_cell (
  input  logic              clk_i,
  input  rvm_pkg::cell_ctl_t ctl_i,
  input  logic [rvm_pkg::IDX_W-1:0] idx_i,
  input  rvm_pkg::vec_t     prev_i,
  output rvm_pkg::vec_t     val_o,
  output rvm_pkg::pick_t    pick_o
);

  rvm_pkg::vec_t val_q, val_d;
  logic [rvm_pkg::CNT_W-1:0] idx_ext;
  logic occupied;
  logic in_range;
  logic first;

  assign idx_ext  = rvm_pkg::CNT_W'(idx_i);
  assign occupied = idx_ext < ctl_i.count;
  assign in_range = idx_ext <= ctl_i.count;
  assign first    = (idx_i == '0);

  // Parallel insertion: a cell keeps its sample if it is not larger than the
  // new one, takes the new sample at the insertion point, and otherwise takes
  // its lower neighbor's sample so the tail moves up by one.
  always_comb begin
    val_d = val_q;
    for (int v = 0; v < rvm_pkg::VARS; v++) begin
      if (ctl_i.ins && in_range &&
          !(occupied && ($signed(val_q[v]) <= $signed(ctl_i.x[v])))) begin
        if (first || ($signed(prev_i[v]) <= $signed(ctl_i.x[v]))) begin
          val_d[v] = ctl_i.x[v];
        end else begin
          val_d[v] = prev_i[v];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_comb begin
    pick_o = '0;
    if (idx_i == ctl_i.idx_lo) begin
      pick_o.lo = val_q;
    end
    if (idx_i == ctl_i.idx_hi) begin
      pick_o.hi = val_q;
    end
  end

  assign val_o = val_q;

endmodule

// File: rtl/rvm_or_tree.sv
// Two-stage registered OR tree that gathers the middle samples from the chain.
// Depends on rvm_pkg.
module rvm_or_tree (
  input  logic                                     clk_i,
  input  rvm_pkg::pick_t [rvm_pkg::CAPACITY-1:0]   leaf_i,
  output rvm_pkg::pick_t                           root_o
);

  rvm_pkg::pick_t [rvm_pkg::NGROUPS-1:0] grp_d, grp_q;
  rvm_pkg::pick_t root_d, root_q;

  // At most one cell drives a nonzero pick per half, so OR acts as a mux.
  always_comb begin
    grp_d = '0;
    for (int g = 0; g < rvm_pkg::NGROUPS; g++) begin
      for (int k = 0; k < rvm_pkg::GROUP; k++) begin
        if (g * rvm_pkg::GROUP + k < rvm_pkg::CAPACITY) begin
          grp_d[g] = grp_d[g] | leaf_i[g * rvm_pkg::GROUP + k];
        end
      end
    end
  end

  always_comb begin
    root_d = '0;
    for (int g = 0; g < rvm_pkg::NGROUPS; g++) begin
      root_d = root_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

// File: dv/vector_running_median_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for vector_running_median: a scoreboard predicts the
// doubled medians per component from every accepted transaction. Depends on rvm_pkg and vector_running_median.
module vector_running_median_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [rvm_pkg::COMP_W-1:0]    component;
    logic [rvm_pkg::MED_W-1:0]     median_doubled;
    logic [rvm_pkg::OUT_CNT_W-1:0] sample_count;
    logic [rvm_pkg::STATUS_W-1:0]  status;
    logic                          last;
  } median_result_t;

  class median_scoreboard;
    int             sorted_col[rvm_pkg::VARS][$];
    int unsigned    stored;
    median_result_t medians_due[$];
    int unsigned    errors;

    function new();
      stored = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Mirrors one accepted transaction: inserts samples or queues the expected results.
    function void take_transaction(logic op, rvm_pkg::vec_t vals);
      median_result_t r;
      int pos;
      int x;
      int h;
      int m;
      r = '0;
      if (op == rvm_pkg::OP_ADD) begin
        if (stored >= rvm_pkg::CAPACITY) begin
          r.sample_count = rvm_pkg::OUT_CNT_W'(stored);
          r.status       = rvm_pkg::STATUS_FULL;
          r.last         = 1'b1;
          medians_due    = {medians_due, r};
        end else begin
          for (int v = 0; v < rvm_pkg::VARS; v++) begin
            x   = $signed(vals[v]);
            pos = 0;
            while (pos < sorted_col[v].size() && sorted_col[v][pos] <= x) pos++;
            sorted_col[v].insert(pos, x);
          end
          stored++;
        end
      end else if (stored == 0) begin
        r.status    = rvm_pkg::STATUS_EMPTY;
        r.last      = 1'b1;
        medians_due = {medians_due, r};
      end else begin
        h = stored / 2;
        for (int v = 0; v < rvm_pkg::VARS; v++) begin
          if (stored % 2 == 1) m = 2 * sorted_col[v][h];
          else m = sorted_col[v][h-1] + sorted_col[v][h];
          r.component      = rvm_pkg::COMP_W'(v);
          r.median_doubled = rvm_pkg::MED_W'(m);
          r.sample_count   = rvm_pkg::OUT_CNT_W'(stored);
          r.status         = rvm_pkg::STATUS_OK;
          r.last           = (v == rvm_pkg::VARS - 1);
          medians_due      = {medians_due, r};
        end
      end
    endfunction

    task check_result(median_result_t got);
      median_result_t want;
      if (medians_due.size() == 0) begin
        report("result arrived with nothing outstanding");
        return;
      end
      want = medians_due.pop_front();
      if (got.component != want.component)
        report($sformatf("component got %0d want %0d", got.component, want.component));
      if (got.median_doubled != want.median_doubled)
        report($sformatf("median_doubled got %0d want %0d (component %0d)",
                         $signed(got.median_doubled), $signed(want.median_doubled),
                         want.component));
      if (got.sample_count != want.sample_count)
        report($sformatf("sample_count got %0d want %0d",
                         got.sample_count, want.sample_count));
      if (got.status != want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.last != want.last)
        report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic                                operation_i;
  logic signed [rvm_pkg::SAMPLE_W-1:0] value_0_i;
  logic signed [rvm_pkg::SAMPLE_W-1:0] value_1_i;
  logic signed [rvm_pkg::SAMPLE_W-1:0] value_2_i;
  logic signed [rvm_pkg::SAMPLE_W-1:0] value_3_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic [rvm_pkg::COMP_W-1:0]          component_o;
  logic signed [rvm_pkg::MED_W-1:0]    median_doubled_o;
  logic [rvm_pkg::OUT_CNT_W-1:0]       sample_count_o;
  logic [rvm_pkg::STATUS_W-1:0]        status_o;
  logic                                last_o;

  median_scoreboard sb = new();
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 83;
  logic        long_hold_req = 1'b0;
  int unsigned cycles = 0;

  vector_running_median uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .value_0_i        (value_0_i),
    .value_1_i        (value_1_i),
    .value_2_i        (value_2_i),
    .value_3_i        (value_3_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .component_o      (component_o),
    .median_doubled_o (median_doubled_o),
    .sample_count_o   (sample_count_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("vector_running_median_tb failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off when requested.
  initial begin
    int unsigned hold_left;
    bit          hold_taken;
    median_result_t got;
    hold_left   = 0;
    hold_taken  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.component      = component_o;
        got.median_doubled = median_doubled_o;
        got.sample_count   = sample_count_o;
        got.status         = status_o;
        got.last           = last_o;
        sb.check_result(got);
      end
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic rvm_pkg::vec_t mk_vec(int a, int b, int c, int d);
    rvm_pkg::vec_t v;
    v[0] = rvm_pkg::SAMPLE_W'(a);
    v[1] = rvm_pkg::SAMPLE_W'(b);
    v[2] = rvm_pkg::SAMPLE_W'(c);
    v[3] = rvm_pkg::SAMPLE_W'(d);
    return v;
  endfunction

  // Mix of full-range, extreme and clustered values so medians hit duplicates.
  function automatic logic [rvm_pkg::SAMPLE_W-1:0] pick_sample();
    logic [rvm_pkg::SAMPLE_W-1:0] s;
    case ($urandom_range(3))
      0: s = rvm_pkg::SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(3))
          0: s = 16'h8000;
          1: s = 16'h7fff;
          2: s = 16'hffff;
          default: s = 16'h0000;
        endcase
      end
      default: s = rvm_pkg::SAMPLE_W'(int'($urandom_range(40)) - 20);
    endcase
    return s;
  endfunction

  function automatic rvm_pkg::vec_t random_vec();
    rvm_pkg::vec_t v;
    for (int i = 0; i < rvm_pkg::VARS; i++) v[i] = pick_sample();
    return v;
  endfunction

  // Holds valid until the transaction is taken; lowers it only for idle gaps.
  task automatic send_item(input logic op, input rvm_pkg::vec_t vals);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_0_i   <= vals[0];
    value_1_i   <= vals[1];
    value_2_i   <= vals[2];
    value_3_i   <= vals[3];
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_transaction(op, vals);
  endtask

  task automatic send_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) send_item(rvm_pkg::OP_QUERY, random_vec());
      else send_item(rvm_pkg::OP_ADD, random_vec());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = rvm_pkg::OP_ADD;
    value_0_i   = '0;
    value_1_i   = '0;
    value_2_i   = '0;
    value_3_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty query, extremes, odd and even counts, back-to-back queries.
    send_item(rvm_pkg::OP_QUERY, mk_vec(-1, -1, -1, -1));
    send_item(rvm_pkg::OP_ADD,   mk_vec(-32768, 32767, 0, -1));
    send_item(rvm_pkg::OP_QUERY, mk_vec(0, 0, 0, 0));
    send_item(rvm_pkg::OP_ADD,   mk_vec(32767, -32768, 16'h5555, 16'haaaa));
    send_item(rvm_pkg::OP_QUERY, mk_vec(0, 0, 0, 0));
    send_item(rvm_pkg::OP_QUERY, mk_vec(-32768, 32767, 0, -1));
    send_item(rvm_pkg::OP_ADD,   mk_vec(32767, 32767, -32768, -32768));
    send_item(rvm_pkg::OP_ADD,   mk_vec(32767, -32768, -32768, -32768));
    send_item(rvm_pkg::OP_QUERY, mk_vec(0, 0, 0, 0));
    send_item(rvm_pkg::OP_ADD,   mk_vec(-32768, -32768, -32768, -32768));
    send_item(rvm_pkg::OP_ADD,   mk_vec(-32768, -32768, -32768, -32768));
    send_item(rvm_pkg::OP_QUERY, mk_vec(0, 0, 0, 0));
    send_item(rvm_pkg::OP_ADD,   mk_vec(0, 16'haaaa, 16'h5555, 1));
    send_item(rvm_pkg::OP_QUERY, mk_vec(0, 0, 0, 0));
    send_item(rvm_pkg::OP_QUERY, mk_vec(0, 0, 0, 0));

    send_random(55);

    send_idle_pct = 83;
    recv_idle_pct = 32;
    send_random(55);

    // No idling; the long receiver stall makes the block back up its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req <= 1'b1;
    send_item(rvm_pkg::OP_QUERY, random_vec());
    send_random(50);

    // Fill the store to capacity, then hit the full case.
    while (sb.stored < rvm_pkg::CAPACITY) begin
      if ($urandom_range(15) == 0) send_item(rvm_pkg::OP_QUERY, random_vec());
      else send_item(rvm_pkg::OP_ADD, random_vec());
    end
    for (int i = 0; i < 4; i++) begin
      send_item(rvm_pkg::OP_ADD, random_vec());
      send_item(rvm_pkg::OP_QUERY, random_vec());
    end
    in_valid_i <= 1'b0;

    while (sb.medians_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("vector_running_median_tb passed");
    end else begin
      $display("vector_running_median_tb failed");
    end
    $finish;
  end

endmodule
